[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL in this folder.
// Every macro expects clk_i and rst_ni in scope; checks are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/r2n_pkg.sv]
// Shared types, constants and helper functions for the RGB to NV21 encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package r2n_pkg;

  localparam int DefaultMaxDimension = 4096;
  localparam int DimW                = 13;
  localparam int CfgIdxW             = 4;
  localparam int QueueDepth          = 2;

  localparam logic [DimW-1:0] FrameWidthReset  = DimW'(640);
  localparam logic [DimW-1:0] FrameHeightReset = DimW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = CfgIdxW'(0),
    CfgFrameHeight = CfgIdxW'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_present;
    logic [7:0] chroma_v;
    logic [7:0] chroma_u;
    logic       end_of_frame;
  } result_t;

  // Classified item handed from the front end to the color math.
  typedef struct packed {
    pixel_t pixel;
    logic   chroma_present;
    logic   end_of_frame;
  } item_t;

  typedef struct packed {
    logic at_origin;
  } front_status_t;

  localparam int SumW = 18;
  typedef logic signed [SumW-1:0] sum_t;

  // Row order: Y, U, V; column order: R, G, B.
  localparam int Coef [9] = '{66, 129, 25, -38, -74, 112, 112, -94, -18};

  localparam sum_t RoundBias = SumW'(128);
  localparam logic signed [10:0] OffsetY = 11'sd16;
  localparam logic signed [10:0] OffsetC = 11'sd128;

  function automatic sum_t mul_coef(logic [7:0] x, int c);
    logic signed [31:0] p;
    p = $signed({24'd0, x}) * c;
    return sum_t'(p);
  endfunction

  // Floor shift by 8, add offset, clamp to a byte.
  function automatic logic [7:0] scale_clamp(sum_t s, logic signed [10:0] off);
    logic signed [10:0] v;
    v = $signed(11'(s >>> 8)) + off;
    if (v < 0) begin
      return 8'd0;
    end else if (v > 11'sd255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

endpackage

[rtl/core/r2n_front.sv]
// Front end: frame size registers, column/row counters and chroma site selection.
// Depends on r2n_pkg.
`timescale 1ns / 1ps

module r2n_front #(
  parameter int MaxDimension = r2n_pkg::DefaultMaxDimension
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [r2n_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [r2n_pkg::DimW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  r2n_pkg::pixel_t              in_data_i,
  input  logic                         queue_ready_i,
  output logic                         push_o,
  output r2n_pkg::item_t               item_o,
  output r2n_pkg::front_status_t       status_o
);

  localparam int CW = $clog2(MaxDimension);
  localparam int EW = $clog2(MaxDimension + 1);

  logic [r2n_pkg::DimW-1:0] width_q, width_d, height_q, height_d;
  logic [CW-1:0]            col_q, col_d, row_q, row_d;
  logic [EW-1:0]            eff_w, eff_h;
  logic                     last_col, last_row, chroma;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = queue_ready_i;
  assign push_o      = in_valid_i && queue_ready_i;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        r2n_pkg::CfgFrameWidth:  width_d  = cfg_data_i;
        r2n_pkg::CfgFrameHeight: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (width_q == '0) begin
      eff_w = EW'(1);
    end else if (32'(width_q) > 32'(MaxDimension)) begin
      eff_w = EW'(MaxDimension);
    end else begin
      eff_w = EW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = EW'(1);
    end else if (32'(height_q) > 32'(MaxDimension)) begin
      eff_h = EW'(MaxDimension);
    end else begin
      eff_h = EW'(height_q);
    end
  end

  // >= so a counter left past the end by a size change counts as last.
  assign last_col = EW'(col_q) >= (eff_w - EW'(1));
  assign last_row = EW'(row_q) >= (eff_h - EW'(1));

  // Odd rows carry no chroma; odd widths shift later even rows to odd columns.
  always_comb begin
    if (row_q[0]) begin
      chroma = 1'b0;
    end else if ((row_q == '0) || !eff_w[0]) begin
      chroma = !col_q[0];
    end else begin
      chroma = col_q[0];
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_comb begin
    item_o.pixel          = in_data_i;
    item_o.chroma_present = chroma;
    item_o.end_of_frame   = last_col && last_row;
    status_o.at_origin    = (col_q == '0) && (row_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= r2n_pkg::FrameWidthReset;
      height_q <= r2n_pkg::FrameHeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

[rtl/core/r2n_queue.sv]
// Short item queue between the front end and the color math.
// Depends on r2n_pkg.
`timescale 1ns / 1ps

module r2n_queue (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  r2n_pkg::item_t                              item_i,
  output logic                                        ready_o,
  input  logic                                        pop_i,
  output logic                                        valid_o,
  output r2n_pkg::item_t                              item_o,
  output logic [$clog2(r2n_pkg::QueueDepth+1)-1:0]    level_o
);

  localparam int PW = $clog2(r2n_pkg::QueueDepth);
  localparam int LW = $clog2(r2n_pkg::QueueDepth + 1);

  r2n_pkg::item_t mem_q [r2n_pkg::QueueDepth];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]  count_q, count_d;
  logic           push, pop;

  assign ready_o = count_q != LW'(r2n_pkg::QueueDepth);
  assign valid_o = count_q != '0;
  assign push    = push_i && ready_o;
  assign pop     = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];
  assign level_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(r2n_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(r2n_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + LW'(1);
      2'b01:   count_d = count_q - LW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/core/r2n_back.sv]
// Back end: BT.601 color math in two registered stages (products, then sums and clamp).
// Depends on r2n_pkg.
`timescale 1ns / 1ps

module r2n_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  r2n_pkg::item_t    item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output r2n_pkg::result_t  out_data_o
);

  logic              a_valid_q, a_valid_d, b_valid_q, b_valid_d;
  logic              a_ready, b_ready, a_load, b_load;
  r2n_pkg::sum_t     prod_q [9];
  r2n_pkg::sum_t     prod_d [9];
  logic              a_chroma_q, a_eof_q;
  logic [7:0]        comp [3];
  r2n_pkg::sum_t     sum_y, sum_u, sum_v;
  r2n_pkg::result_t  res_d, res_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;
  assign a_load     = in_valid_i && a_ready;
  assign b_load     = a_valid_q && b_ready;

  assign a_valid_d = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_q);
  assign b_valid_d = b_load ? 1'b1 : (out_ready_i ? 1'b0 : b_valid_q);

  always_comb begin
    comp[0] = item_i.pixel.red;
    comp[1] = item_i.pixel.green;
    comp[2] = item_i.pixel.blue;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i*3+j] = r2n_pkg::mul_coef(comp[j], r2n_pkg::Coef[i*3+j]);
      end
    end
  end

  always_comb begin
    sum_y = prod_q[0] + prod_q[1] + prod_q[2] + r2n_pkg::RoundBias;
    sum_u = prod_q[3] + prod_q[4] + prod_q[5] + r2n_pkg::RoundBias;
    sum_v = prod_q[6] + prod_q[7] + prod_q[8] + r2n_pkg::RoundBias;
    res_d.luma           = r2n_pkg::scale_clamp(sum_y, r2n_pkg::OffsetY);
    res_d.chroma_present = a_chroma_q;
    res_d.chroma_v       = a_chroma_q ? r2n_pkg::scale_clamp(sum_v, r2n_pkg::OffsetC) : 8'd0;
    res_d.chroma_u       = a_chroma_q ? r2n_pkg::scale_clamp(sum_u, r2n_pkg::OffsetC) : 8'd0;
    res_d.end_of_frame   = a_eof_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      prod_q     <= prod_d;
      a_chroma_q <= item_i.chroma_present;
      a_eof_q    <= item_i.end_of_frame;
    end
    if (b_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = res_q;

endmodule

[rtl/core/rgb_to_nv21_pixel_encoder.sv]
// RGB to NV21 pixel encoder: one RGB pixel in, one luma result (with V/U at chroma
// sites) out. Sustains one pixel per clock while out_ready_i does not hold back the
// output; each result passes through the two-entry item queue and the two-stage
// product/sum pipeline of the color math. Frame size registers may be written any
// time the block is idle; a new size takes effect once it is registered and leaves
// the position counters where they are. Depends on r2n_pkg, r2n_front, r2n_queue, r2n_back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_nv21_pixel_encoder #(
  parameter int MaxDimension = r2n_pkg::DefaultMaxDimension
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [r2n_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [r2n_pkg::DimW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  r2n_pkg::pixel_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output r2n_pkg::result_t             out_data_o
);

  r2n_pkg::item_t         front_item, queue_item;
  r2n_pkg::front_status_t front_status;
  logic                   queue_ready, push, queue_valid, back_ready;
  logic [$clog2(r2n_pkg::QueueDepth+1)-1:0] queue_level;
  logic                   chroma_bytes_zero;

  r2n_front #(
    .MaxDimension (MaxDimension)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .item_o        (front_item),
    .status_o      (front_status)
  );

  r2n_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (queue_ready),
    .pop_i   (back_ready),
    .valid_o (queue_valid),
    .item_o  (queue_item),
    .level_o (queue_level)
  );

  r2n_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (queue_valid),
    .in_ready_o  (back_ready),
    .item_i      (queue_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign chroma_bytes_zero = (out_data_o.chroma_v == 8'd0) && (out_data_o.chroma_u == 8'd0);

  // Counters must sit at the frame origin right after the last pixel of a frame.
  `ASSERT_NEXT(a_eof_wraps, push && front_item.end_of_frame, front_status.at_origin)
  // Non-sample pixels never carry stale chroma.
  `ASSERT_IMPLIES(a_no_chroma_zero, out_valid_o && !out_data_o.chroma_present, chroma_bytes_zero)
  `ASSERT_ALWAYS(a_queue_bound, queue_level <= r2n_pkg::QueueDepth)

endmodule
